// ===== hw/rtl/apse_pkg.sv =====
// Shared types and constants of the Annex B parameter-set extractor.
package apse_pkg;

    // Configuration register indexes
    localparam logic CFG_CODEC_SELECT   = 1'b0;
    localparam logic CFG_EXTRACT_ENABLE = 1'b1;

    // Look-ahead window depth (start code plus type byte)
    localparam int WIN_DEPTH = 5;

    // NAL type codes that open a parameter-set group
    localparam logic [4:0] H264_SPS_TYPE = 5'd7;
    localparam logic [5:0] H265_VPS_TYPE = 6'd32;

    // NAL count after the first NAL of a group, per codec
    localparam logic [2:0] H264_GROUP_EXTRA = 3'd2;
    localparam logic [2:0] H265_GROUP_EXTRA = 3'd3;

    // Group tracker state
    typedef struct packed {
        logic       seen_start;
        logic       group_active;
        logic [2:0] nal_in_group;
        logic       group_complete;
    } apse_track_t;

    // Outcome of classifying the oldest window byte
    typedef struct packed {
        logic fwd;
        logic nal_begin;
    } apse_class_t;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       nal_begin;
        logic       run_last;
        logic       stream_done;
        logic       group_found;
    } apse_result_t;

endpackage

// ===== hw/rtl/apse_classify.sv =====
// Start-code detection and group tracking for the oldest byte of the window.
module apse_classify (
    input  logic [4:0][7:0]       win,
    input  logic [2:0]            avail,
    input  logic                  codec_sel,
    input  logic                  extract_en,
    input  apse_pkg::apse_track_t trk_in,
    output apse_pkg::apse_track_t trk_out,
    output apse_pkg::apse_class_t cls
);

    logic       sc;
    logic       match;
    logic [2:0] group_extra;

    // Detect a four-byte start code and a parameter-set type byte behind it
    always_comb begin
        sc = (avail >= 3'd4) && (win[0] == 8'h00) && (win[1] == 8'h00) &&
             (win[2] == 8'h00) && (win[3] == 8'h01);
        group_extra = codec_sel ? apse_pkg::H265_GROUP_EXTRA : apse_pkg::H264_GROUP_EXTRA;
        if (avail < 3'd5) begin
            match = 1'b0;
        end else if (codec_sel) begin
            match = (win[4][6:1] == apse_pkg::H265_VPS_TYPE);
        end else begin
            match = (win[4][4:0] == apse_pkg::H264_SPS_TYPE);
        end
    end

    // Advance the group tracker on a start code
    always_comb begin
        trk_out = trk_in;
        if (sc) begin
            trk_out.seen_start = 1'b1;
            if (trk_in.group_complete) begin
                trk_out.group_active = 1'b0;
            end else if (trk_in.group_active) begin
                if (trk_in.nal_in_group >= group_extra) begin
                    trk_out.group_active   = 1'b0;
                    trk_out.group_complete = 1'b1;
                end else begin
                    trk_out.nal_in_group = trk_in.nal_in_group + 3'd1;
                end
            end else if (match) begin
                trk_out.group_active = 1'b1;
                trk_out.nal_in_group = 3'd0;
            end
        end
    end

    // Forward once a start code was seen, and in extract mode only inside the group
    always_comb begin
        cls.fwd       = trk_out.seen_start && !(extract_en && !trk_out.group_active);
        cls.nal_begin = cls.fwd && sc;
    end

endmodule

// ===== hw/rtl/annexb_parameter_set_extractor.sv =====
// Top level of the Annex B parameter-set extractor.
// Takes one stream byte per clock on s_ while no flush runs and the result queue has
// room, and gives at most one forwarded byte per stream byte on m_, four bytes
// behind the input while the five-byte start-code window fills. A request with
// s_tlast set starts a flush: the held bytes leave one per cycle through the shared
// classifier while the result queue has room, then a final request carries
// stream_done. s_tready is low throughout the flush. A two-entry result queue
// lets the input keep moving while a result waits. Configuration writes are taken
// in any cycle and act on the next byte that leaves the window.
module annexb_parameter_set_extractor (
    input  logic       aclk,
    input  logic       aresetn,
    // Stream input
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte
    input  logic       s_tlast,    // end_of_data
    // Result output
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic       m_tlast,    // run_last
    output logic [3:0] m_tuser,    // [0] byte_valid, [1] nal_begin, [2] stream_done,
                                   // [3] group_found
    // Configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic       cfg_data
);

    logic                  codec_reg;
    logic                  extract_reg;
    logic [4:0][7:0]       win_reg;
    logic [2:0]            fill_reg;
    logic                  flush_reg;
    apse_pkg::apse_track_t trk_reg;
    logic                  pend_valid_reg;
    logic [7:0]            pend_byte_reg;
    logic                  pend_begin_reg;

    apse_pkg::apse_result_t fifo_reg [2];
    logic                   wr_ptr_reg;
    logic                   rd_ptr_reg;
    logic [1:0]             count_reg;

    logic [4:0][7:0]       cls_win;
    logic [2:0]            cls_avail;
    apse_pkg::apse_track_t trk_calc;
    apse_pkg::apse_class_t cls;

    logic                   s_acc;
    logic                   m_acc;
    logic                   fifo_room;
    logic                   normal_step;
    logic                   flush_step;
    logic                   flush_final;
    logic                   push;
    apse_pkg::apse_result_t push_data;

    // Classify the oldest byte of the window completed by the input byte, or the oldest held byte in a flush
    always_comb begin
        cls_win   = flush_reg ? win_reg : {s_tdata, win_reg[3:0]};
        cls_avail = flush_reg ? fill_reg : 3'd5;
    end

    apse_classify u_classify (
        .win        (cls_win),
        .avail      (cls_avail),
        .codec_sel  (codec_reg),
        .extract_en (extract_reg),
        .trk_in     (trk_reg),
        .trk_out    (trk_calc),
        .cls        (cls)
    );

    // Handshakes and step decode
    always_comb begin
        fifo_room   = (count_reg != 2'd2);
        s_tready    = !flush_reg && fifo_room;
        cfg_ready   = 1'b1;
        s_acc       = s_tvalid && s_tready;
        m_acc       = m_tvalid && m_tready;
        normal_step = s_acc && !s_tlast && (fill_reg == 3'd4);
        flush_step  = flush_reg && (fill_reg != 3'd0) &&
                      (!(cls.fwd && pend_valid_reg) || fifo_room);
        flush_final = flush_reg && (fill_reg == 3'd0) && fifo_room;
    end

    // Select the request to queue
    always_comb begin
        push      = 1'b0;
        push_data = '0;
        if (normal_step && cls.fwd) begin
            push                 = 1'b1;
            push_data.out_byte   = win_reg[0];
            push_data.byte_valid = 1'b1;
            push_data.nal_begin  = cls.nal_begin;
            push_data.run_last   = 1'b1;
        end else if (flush_step && cls.fwd && pend_valid_reg) begin
            push                 = 1'b1;
            push_data.out_byte   = pend_byte_reg;
            push_data.byte_valid = 1'b1;
            push_data.nal_begin  = pend_begin_reg;
        end else if (flush_final) begin
            push                  = 1'b1;
            push_data.out_byte    = pend_valid_reg ? pend_byte_reg : 8'h00;
            push_data.byte_valid  = pend_valid_reg;
            push_data.nal_begin   = pend_valid_reg && pend_begin_reg;
            push_data.run_last    = 1'b1;
            push_data.stream_done = 1'b1;
            push_data.group_found = trk_reg.group_active || trk_reg.group_complete;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codec_reg   <= 1'b0;
            extract_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == apse_pkg::CFG_CODEC_SELECT) begin
                codec_reg <= cfg_data;
            end
            if (cfg_index == apse_pkg::CFG_EXTRACT_ENABLE) begin
                extract_reg <= cfg_data;
            end
        end
    end

    // Window, flush control, pending byte and group tracker
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg        <= '0;
            fill_reg       <= 3'd0;
            flush_reg      <= 1'b0;
            trk_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_byte_reg  <= 8'h00;
            pend_begin_reg <= 1'b0;
        end else if (flush_reg) begin
            if (flush_step) begin
                // Drop the oldest byte, keep a forwarded one until the next is known
                trk_reg  <= trk_calc;
                win_reg  <= {8'h00, win_reg[4:1]};
                fill_reg <= fill_reg - 3'd1;
                if (cls.fwd) begin
                    pend_valid_reg <= 1'b1;
                    pend_byte_reg  <= win_reg[0];
                    pend_begin_reg <= cls.nal_begin;
                end
            end else if (flush_final) begin
                win_reg        <= '0;
                fill_reg       <= 3'd0;
                flush_reg      <= 1'b0;
                trk_reg        <= '0;
                pend_valid_reg <= 1'b0;
            end
        end else if (s_acc) begin
            if (s_tlast) begin
                // Append the last byte and start the flush
                for (int i = 0; i < apse_pkg::WIN_DEPTH; i++) begin
                    if (fill_reg == 3'(i)) begin
                        win_reg[i] <= s_tdata;
                    end
                end
                fill_reg       <= fill_reg + 3'd1;
                flush_reg      <= 1'b1;
                pend_valid_reg <= 1'b0;
            end else if (fill_reg == 3'd4) begin
                // Advance the full window
                trk_reg    <= trk_calc;
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= win_reg[3];
                win_reg[3] <= s_tdata;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    if (fill_reg == 3'(i)) begin
                        win_reg[i] <= s_tdata;
                    end
                end
                fill_reg <= fill_reg + 3'd1;
            end
        end
    end

    // Result queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (m_acc) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, m_acc};
        end
    end

    // Result queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Drive the result port from the queue head
    always_comb begin
        m_tvalid   = (count_reg != 2'd0);
        m_tdata    = fifo_reg[rd_ptr_reg].out_byte;
        m_tlast    = fifo_reg[rd_ptr_reg].run_last;
        m_tuser[0] = fifo_reg[rd_ptr_reg].byte_valid;
        m_tuser[1] = fifo_reg[rd_ptr_reg].nal_begin;
        m_tuser[2] = fifo_reg[rd_ptr_reg].stream_done;
        m_tuser[3] = fifo_reg[rd_ptr_reg].group_found;
    end

    // No new byte is taken while the window drains
    assert property (@(posedge aclk) disable iff (!aresetn) flush_reg |-> !s_tready)
        else $error("input accepted during flush");

    // Queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2) |-> !push)
        else $error("result queue overflow");

    // The closing request returns the stream state to its start
    assert property (@(posedge aclk) disable iff (!aresetn)
        flush_final |=> (fill_reg == 3'd0) && !flush_reg && !trk_reg.seen_start)
        else $error("stream state not cleared after end marker");

    // A done request is always the last of its run
    assert property (@(posedge aclk) disable iff (!aresetn)
        push && push_data.stream_done |-> push_data.run_last && flush_reg)
        else $error("stream_done without run_last");

endmodule
